// ----- hdl/i2cdap_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cdap_pkg
// Shared types and constants for the I2C DAC address programming sequencer.
// ----------------------------------------------------------------------------
package i2cdap_pkg;

  // Register widths
  localparam int unsigned HalfWidth    = 16;
  localparam int unsigned StretchWidth = 24;
  localparam int unsigned SettleWidth  = 16;
  localparam int unsigned EeWidth      = 24;
  localparam int unsigned CfgDataWidth = 24;
  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned WaitWidth    = 24;

  // Register indexes on the configuration port
  localparam logic [CfgIdxWidth-1:0] REG_HALF_STEP = 2'd0;
  localparam logic [CfgIdxWidth-1:0] REG_STRETCH   = 2'd1;
  localparam logic [CfgIdxWidth-1:0] REG_SETTLE    = 2'd2;
  localparam logic [CfgIdxWidth-1:0] REG_EE_WAIT   = 2'd3;

  // Register reset values
  localparam logic [HalfWidth-1:0]    HALF_STEP_RST = 16'd3;
  localparam logic [StretchWidth-1:0] STRETCH_RST   = 24'd5000;
  localparam logic [SettleWidth-1:0]  SETTLE_RST    = 16'd10;
  localparam logic [EeWidth-1:0]      EE_WAIT_RST   = 24'd100000;

  // Base values of the four bytes sent on the bus
  localparam logic [7:0] BYTE0_BASE = 8'hC0;
  localparam logic [7:0] BYTE1_BASE = 8'h61;
  localparam logic [7:0] BYTE2_BASE = 8'h62;
  localparam logic [7:0] BYTE3_BASE = 8'h63;

  // Timing registers as seen by the sequencer
  typedef struct packed {
    logic [HalfWidth-1:0]    half_step;
    logic [StretchWidth-1:0] stretch_limit;
    logic [SettleWidth-1:0]  settle;
    logic [EeWidth-1:0]      eeprom_wait;
  } timing_t;

  // One result item
  typedef struct packed {
    logic       scl_pull_low;
    logic       sda_pull_low;
    logic       latch_level;
    logic       busy;
    logic       done;
    logic       success;
    logic [2:0] failed_byte;
  } result_t;

endpackage

`default_nettype wire

// ----- hdl/i2cdap_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cdap_seq
// Bit-bang I2C sequencer state: steps once per accepted request and
// presents the result for that request.
// ----------------------------------------------------------------------------
module i2cdap_seq (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               advance,
  input  wire i2cdap_pkg::timing_t timing,
  input  wire logic               operation,
  input  wire logic [2:0]         old_bits,
  input  wire logic [2:0]         new_bits,
  input  wire logic               scl_in,
  input  wire logic               sda_in,
  output i2cdap_pkg::result_t     result
);

  typedef enum logic [4:0] {
    PH_IDLE   = 5'd0,
    PH_SETTLE = 5'd1,
    PH_ST_W   = 5'd2,
    PH_ST_D1  = 5'd3,
    PH_ST_D2  = 5'd4,
    PH_ST_D3  = 5'd5,
    PH_BIT_D1 = 5'd6,
    PH_BIT_W  = 5'd7,
    PH_BIT_D2 = 5'd8,
    PH_BIT_D3 = 5'd9,
    PH_ACK_D1 = 5'd10,
    PH_ACK_W  = 5'd11,
    PH_ACK_D2 = 5'd12,
    PH_ACK_D3 = 5'd13,
    PH_SP_D1  = 5'd14,
    PH_SP_W   = 5'd15,
    PH_SP_D2  = 5'd16,
    PH_SP_D3  = 5'd17,
    PH_EE     = 5'd18
  } phase_t;

  localparam int unsigned WW = i2cdap_pkg::WaitWidth;

  phase_t        phase, phase_next;
  logic [WW-1:0] wait_count, wait_count_next;
  logic [2:0]    bit_index, bit_index_next;
  logic [1:0]    byte_index, byte_index_next;
  logic [7:0]    shift_byte, shift_byte_next;
  logic [2:0]    held_old, held_old_next;
  logic [2:0]    held_new, held_new_next;
  logic          ok_flag, ok_flag_next;
  logic          latch_state, latch_state_next;
  logic          scl_drive, scl_drive_next;
  logic          sda_drive, sda_drive_next;
  logic          done_next;
  logic [WW-1:0] half_ext;
  logic [7:0]    next_byte;
  logic [1:0]    next_idx;

  // Byte pattern for a given position in the sequence
  function automatic logic [7:0] byte_value(input logic [1:0] idx,
                                            input logic [2:0] ob,
                                            input logic [2:0] nb);
    logic [7:0] v;
    case (idx)
      2'd0:    v = i2cdap_pkg::BYTE0_BASE | {4'b0, ob, 1'b0};
      2'd1:    v = i2cdap_pkg::BYTE1_BASE | {3'b0, ob, 2'b0};
      2'd2:    v = i2cdap_pkg::BYTE2_BASE | {3'b0, nb, 2'b0};
      default: v = i2cdap_pkg::BYTE3_BASE | {3'b0, nb, 2'b0};
    endcase
    return v;
  endfunction

  assign half_ext = {{(WW - i2cdap_pkg::HalfWidth){1'b0}}, timing.half_step};

  // Index and pattern of the byte that a byte start would load
  always_comb begin
    next_idx  = (phase == PH_ACK_D3) ? byte_index + 2'd1 : 2'd0;
    next_byte = byte_value(next_idx, held_old, held_new);
  end

  // Next state for one request
  always_comb begin
    phase_next       = phase;
    wait_count_next  = wait_count;
    bit_index_next   = bit_index;
    byte_index_next  = byte_index;
    shift_byte_next  = shift_byte;
    held_old_next    = held_old;
    held_new_next    = held_new;
    ok_flag_next     = ok_flag;
    latch_state_next = latch_state;
    scl_drive_next   = scl_drive;
    sda_drive_next   = sda_drive;
    done_next        = 1'b0;

    if (phase == PH_IDLE) begin
      if (operation) begin
        held_old_next    = old_bits;
        held_new_next    = new_bits;
        ok_flag_next     = 1'b1;
        latch_state_next = 1'b1;
        byte_index_next  = 2'd0;
        bit_index_next   = 3'd7;
        shift_byte_next  = 8'd0;
        scl_drive_next   = 1'b0;
        sda_drive_next   = 1'b0;
        phase_next       = PH_SETTLE;
        wait_count_next  = {{(WW - i2cdap_pkg::SettleWidth){1'b0}}, timing.settle};
      end
    end else if (phase == PH_ST_W || phase == PH_BIT_W ||
                 phase == PH_ACK_W || phase == PH_SP_W) begin
      // SCL release wait, bounded by the stretch limit
      if (scl_in || wait_count >= timing.stretch_limit) begin
        wait_count_next = half_ext;
        case (phase)
          PH_ST_W:  phase_next = PH_ST_D1;
          PH_BIT_W: phase_next = PH_BIT_D2;
          PH_ACK_W: phase_next = PH_ACK_D2;
          default:  phase_next = PH_SP_D2;
        endcase
      end else begin
        wait_count_next = wait_count + WW'(1);
      end
    end else if (wait_count > 24'd1) begin
      wait_count_next = wait_count - WW'(1);
    end else begin
      case (phase)
        PH_SETTLE: begin
          sda_drive_next  = 1'b0;
          scl_drive_next  = 1'b0;
          phase_next      = PH_ST_W;
          wait_count_next = '0;
        end
        PH_ST_D1: begin
          sda_drive_next  = 1'b1;
          phase_next      = PH_ST_D2;
          wait_count_next = half_ext;
        end
        PH_ST_D2: begin
          scl_drive_next  = 1'b1;
          phase_next      = PH_ST_D3;
          wait_count_next = half_ext;
        end
        PH_ST_D3: begin
          byte_index_next = next_idx;
          shift_byte_next = next_byte;
          bit_index_next  = 3'd7;
          sda_drive_next  = ~next_byte[7];
          phase_next      = PH_BIT_D1;
          wait_count_next = half_ext;
        end
        PH_BIT_D1: begin
          scl_drive_next  = 1'b0;
          phase_next      = PH_BIT_W;
          wait_count_next = '0;
        end
        PH_BIT_D2: begin
          scl_drive_next = 1'b1;
          // latch drops with SCL on the last bit of the second byte
          if (byte_index == 2'd1 && bit_index == 3'd0) begin
            latch_state_next = 1'b0;
          end
          phase_next      = PH_BIT_D3;
          wait_count_next = half_ext;
        end
        PH_BIT_D3: begin
          if (bit_index == 3'd0) begin
            sda_drive_next = 1'b0;
            phase_next     = PH_ACK_D1;
          end else begin
            bit_index_next = bit_index - 3'd1;
            sda_drive_next = ~shift_byte[bit_index - 3'd1];
            phase_next     = PH_BIT_D1;
          end
          wait_count_next = half_ext;
        end
        PH_ACK_D1: begin
          scl_drive_next  = 1'b0;
          phase_next      = PH_ACK_W;
          wait_count_next = '0;
        end
        PH_ACK_D2: begin
          if (sda_in) begin
            ok_flag_next = 1'b0;
          end
          scl_drive_next  = 1'b1;
          phase_next      = PH_ACK_D3;
          wait_count_next = half_ext;
        end
        PH_ACK_D3: begin
          if (ok_flag && byte_index != 2'd3) begin
            byte_index_next = next_idx;
            shift_byte_next = next_byte;
            bit_index_next  = 3'd7;
            sda_drive_next  = ~next_byte[7];
            phase_next      = PH_BIT_D1;
          end else begin
            sda_drive_next = 1'b1;
            phase_next     = PH_SP_D1;
          end
          wait_count_next = half_ext;
        end
        PH_SP_D1: begin
          scl_drive_next  = 1'b0;
          phase_next      = PH_SP_W;
          wait_count_next = '0;
        end
        PH_SP_D2: begin
          sda_drive_next  = 1'b0;
          phase_next      = PH_SP_D3;
          wait_count_next = half_ext;
        end
        PH_SP_D3: begin
          phase_next      = PH_EE;
          wait_count_next = timing.eeprom_wait;
        end
        PH_EE: begin
          latch_state_next = 1'b1;
          done_next        = 1'b1;
          phase_next       = PH_IDLE;
          wait_count_next  = '0;
        end
        default: begin
          phase_next       = PH_IDLE;
          wait_count_next  = '0;
          scl_drive_next   = 1'b0;
          sda_drive_next   = 1'b0;
          latch_state_next = 1'b1;
        end
      endcase
    end
  end

  // Result reflects the state after this request
  always_comb begin
    result.scl_pull_low = scl_drive_next;
    result.sda_pull_low = sda_drive_next;
    result.latch_level  = latch_state_next;
    result.busy         = (phase_next != PH_IDLE);
    result.done         = done_next;
    result.success      = done_next & ok_flag_next;
    result.failed_byte  = (done_next && !ok_flag_next) ?
                          ({1'b0, byte_index_next} + 3'd1) : 3'd0;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      wait_count  <= '0;
      bit_index   <= 3'd7;
      byte_index  <= 2'd0;
      shift_byte  <= 8'd0;
      held_old    <= 3'd0;
      held_new    <= 3'd0;
      ok_flag     <= 1'b1;
      latch_state <= 1'b1;
      scl_drive   <= 1'b0;
      sda_drive   <= 1'b0;
    end else if (advance) begin
      phase       <= phase_next;
      wait_count  <= wait_count_next;
      bit_index   <= bit_index_next;
      byte_index  <= byte_index_next;
      shift_byte  <= shift_byte_next;
      held_old    <= held_old_next;
      held_new    <= held_new_next;
      ok_flag     <= ok_flag_next;
      latch_state <= latch_state_next;
      scl_drive   <= scl_drive_next;
      sda_drive   <= sda_drive_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/i2c_dac_address_program_sequencer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_dac_address_program_sequencer
// Tick-driven open-drain I2C master that rewrites a DAC's address bits.
// ----------------------------------------------------------------------------
// Each input request is one time tick (or a start command with the old and
// new address bits) together with sampled SCL/SDA levels; each request gives
// exactly one result with the line drives, latch level and status. One
// request is taken every clock unless the input stalls; the sequencer state
// steps and the result lands in an output register, seen the next cycle.
// The input stalls only while that output register holds a result that is
// not being taken. All bus timing is counted in requests, set by the four
// timing registers; configure them only while the sequencer is idle.
module i2c_dac_address_program_sequencer (
  input  wire logic        clk,
  input  wire logic        rst,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        operation,
  input  wire logic [2:0]  old_bits,
  input  wire logic [2:0]  new_bits,
  input  wire logic        scl_in,
  input  wire logic        sda_in,
  // output channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             scl_pull_low,
  output logic             sda_pull_low,
  output logic             latch_level,
  output logic             busy_res,
  output logic             done_res,
  output logic             success,
  output logic [2:0]       failed_byte,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);

  i2cdap_pkg::timing_t timing;
  i2cdap_pkg::result_t result;
  i2cdap_pkg::result_t out_reg;
  logic                accept;

  // Request accepted when the output slot is free or draining
  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  // Timing registers
  always_ff @(posedge clk) begin
    if (rst) begin
      timing.half_step     <= i2cdap_pkg::HALF_STEP_RST;
      timing.stretch_limit <= i2cdap_pkg::STRETCH_RST;
      timing.settle        <= i2cdap_pkg::SETTLE_RST;
      timing.eeprom_wait   <= i2cdap_pkg::EE_WAIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        i2cdap_pkg::REG_HALF_STEP: timing.half_step     <= cfg_data[15:0];
        i2cdap_pkg::REG_STRETCH:   timing.stretch_limit <= cfg_data;
        i2cdap_pkg::REG_SETTLE:    timing.settle        <= cfg_data[15:0];
        i2cdap_pkg::REG_EE_WAIT:   timing.eeprom_wait   <= cfg_data;
        default: ;
      endcase
    end
  end

  i2cdap_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .advance   (accept),
    .timing    (timing),
    .operation (operation),
    .old_bits  (old_bits),
    .new_bits  (new_bits),
    .scl_in    (scl_in),
    .sda_in    (sda_in),
    .result    (result)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_reg <= result;
    end
  end

  assign scl_pull_low = out_reg.scl_pull_low;
  assign sda_pull_low = out_reg.sda_pull_low;
  assign latch_level  = out_reg.latch_level;
  assign busy_res     = out_reg.busy;
  assign done_res     = out_reg.done;
  assign success      = out_reg.success;
  assign failed_byte  = out_reg.failed_byte;

endmodule

`default_nettype wire
